>>> rtl/biquad_iir_filter_defines.svh
// Assertion helpers shared by the biquad RTL.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef BIQUAD_IIR_FILTER_DEFINES_SVH
`define BIQUAD_IIR_FILTER_DEFINES_SVH

// Same-cycle implication
`define BIQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/biq_pkg.sv
`default_nettype none

package biq_pkg;

	// Default sizes
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int COEF_FRAC_BITS_DEF = 22;

	// Coefficient register file
	localparam int NUM_COEFS = 5;
	localparam int CFG_IDX_W = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register indexes, also used as coefficient array indexes
	localparam cfg_idx_t CFG_B0 = 3'd0;
	localparam cfg_idx_t CFG_B1 = 3'd1;
	localparam cfg_idx_t CFG_B2 = 3'd2;
	localparam cfg_idx_t CFG_A1 = 3'd3;
	localparam cfg_idx_t CFG_A2 = 3'd4;

endpackage

`default_nettype wire

>>> rtl/biq_coef_regs.sv
`default_nettype none

module biq_coef_regs
	import biq_pkg::*;
#(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
	parameter int COEF_W         = COEF_FRAC_BITS + 2
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire cfg_idx_t                 cfg_index,
	input  wire logic [COEF_W-1:0]        cfg_data,
	output logic signed [COEF_W-1:0]      coefs [NUM_COEFS]
);

	// b0 resets to unity gain
	localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(1) << COEF_FRAC_BITS;

	logic signed [COEF_W-1:0] coef_q [NUM_COEFS];

	// Writes are always taken
	assign cfg_ready = 1'b1;

	// Coefficient registers; indexes past a2 are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[CFG_B0] <= B0_RESET;
			coef_q[CFG_B1] <= '0;
			coef_q[CFG_B2] <= '0;
			coef_q[CFG_A1] <= '0;
			coef_q[CFG_A2] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_B0:  coef_q[CFG_B0] <= cfg_data;
				CFG_B1:  coef_q[CFG_B1] <= cfg_data;
				CFG_B2:  coef_q[CFG_B2] <= cfg_data;
				CFG_A1:  coef_q[CFG_A1] <= cfg_data;
				CFG_A2:  coef_q[CFG_A2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coefs = coef_q;

endmodule

`default_nettype wire

>>> rtl/biq_core.sv
`default_nettype none

`include "biquad_iir_filter_defines.svh"

module biq_core
	import biq_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
	parameter int COEF_W         = COEF_FRAC_BITS + 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          advance,
	input  wire logic signed [SAMPLE_WIDTH-1:0] x,
	input  wire logic signed [COEF_W-1:0]       coefs [NUM_COEFS],
	output logic signed [SAMPLE_WIDTH-1:0]      y
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int PROD_W = SW + COEF_W;
	localparam int ACC_W  = PROD_W + 3;

	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_MAX  = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN  = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

	// History: newest input, previous input, three outputs
	logic signed [SW-1:0] in0_q, in1_q;
	logic signed [SW-1:0] out0_q, out1_q, out2_q;

	logic                 prime;
	logic signed [SW-1:0] x1_eff, x2_eff, y1_eff, y2_eff;
	logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_W-1:0]  acc, acc_rnd, acc_shr;

	// Empty oldest output word primes all taps with the new sample
	assign prime  = (out2_q == '0);
	assign x1_eff = prime ? x : in0_q;
	assign x2_eff = prime ? x : in1_q;
	assign y1_eff = prime ? x : out0_q;
	assign y2_eff = prime ? x : out1_q;

	// Five parallel products
	assign p_b0 = PROD_W'(x)      * PROD_W'(coefs[CFG_B0]);
	assign p_b1 = PROD_W'(x1_eff) * PROD_W'(coefs[CFG_B1]);
	assign p_b2 = PROD_W'(x2_eff) * PROD_W'(coefs[CFG_B2]);
	assign p_a1 = PROD_W'(y1_eff) * PROD_W'(coefs[CFG_A1]);
	assign p_a2 = PROD_W'(y2_eff) * PROD_W'(coefs[CFG_A2]);

	// Sum, round half up, drop fraction
	assign acc = ACC_W'(p_b2) + ACC_W'(p_b1) + ACC_W'(p_b0) + ACC_W'(p_a2) + ACC_W'(p_a1);
	assign acc_rnd = acc + HALF_LSB;
	assign acc_shr = acc_rnd >>> COEF_FRAC_BITS;

	// Clamp to sample range
	always_comb begin
		priority if (acc_shr > SAT_MAX) begin
			y = SAT_MAX[SW-1:0];
		end else if (acc_shr < SAT_MIN) begin
			y = SAT_MIN[SW-1:0];
		end else begin
			y = acc_shr[SW-1:0];
		end
	end

	// History shifts once per processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in0_q  <= '0;
			in1_q  <= '0;
			out0_q <= '0;
			out1_q <= '0;
			out2_q <= '0;
		end else if (advance) begin
			in0_q  <= x;
			in1_q  <= x1_eff;
			out0_q <= y;
			out1_q <= y1_eff;
			out2_q <= y2_eff;
		end
	end

	`BIQ_ASSERT_NEXT(a_hist_hold, !advance, $stable(in0_q) && $stable(out0_q) && $stable(out2_q), "history moved without a sample")
	`BIQ_ASSERT_NEXT(a_prime_fill, advance && prime, (in1_q == out1_q) && (out1_q == out2_q), "priming did not fill the taps")

endmodule

`default_nettype wire

>>> rtl/biquad_iir_filter.sv
// Channel   Handshake              Payload
// smp       smp_valid / smp_stall  sample_in  (signed, SAMPLE_WIDTH)
// res       res_valid / res_stall  sample_out (signed, SAMPLE_WIDTH)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (signed Q2.COEF_FRAC_BITS)
//
// One sample per cycle unless the result stalls; each sample is held in the input
// register, then makes one pass through five multipliers, adder, round and clamp.
// The rate is set by the output feedback: each sample needs the last result.
// Reset clears history and sets b0 = 1.0, other coefficients 0.
// A stalled result holds the input stage; smp_stall rises only while it is full.
`default_nettype none

`include "biquad_iir_filter_defines.svh"

module biquad_iir_filter
	import biq_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
	parameter int COEF_W         = COEF_FRAC_BITS + 2
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           smp_valid,
	output logic                                smp_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire cfg_idx_t                       cfg_index,
	input  wire logic [COEF_W-1:0]              cfg_data
);

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic                           res_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] res_sample_q;
	logic                           adv;
	logic signed [SAMPLE_WIDTH-1:0] y_next;
	logic signed [COEF_W-1:0]       coefs [NUM_COEFS];

	// Coefficient registers
	biq_coef_regs #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.COEF_W         (COEF_W)
	) u_coefs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	// Filter arithmetic and history
	biq_core #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.COEF_W         (COEF_W)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv),
		.x       (sample_s1),
		.coefs   (coefs),
		.y       (y_next)
	);

	// Input stage moves on when the result register is free or draining
	assign adv       = valid_s1 && (!res_valid_q || !res_stall);
	assign smp_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp_valid && !smp_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (smp_valid && !smp_stall) begin
			sample_s1 <= sample_in;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_sample_q <= y_next;
		end
	end

	assign res_valid  = res_valid_q;
	assign sample_out = res_sample_q;

	`BIQ_ASSERT_IMP(a_stall_needs_item, smp_stall, valid_s1 && res_valid_q, "stall without a blocked item")
	`BIQ_ASSERT_NEXT(a_adv_fills_res, adv, res_valid_q, "processed sample lost before result register")

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import biq_pkg::*;

	localparam int SW          = SAMPLE_WIDTH_DEF;
	localparam int CFB         = COEF_FRAC_BITS_DEF;
	localparam int COEF_W      = CFB + 2;
	localparam int HALF_PERIOD = 5;
	localparam int IDLE_PCT    = 19;
	localparam int STUCK_LIMIT = 2000;
	localparam int MAX_SHOWN   = 10;
	localparam int TAIL_CYCLES = 10;
	localparam int RAND_PHASES = 10;
	localparam int PHASE_ITEMS = 145;
	localparam int CALM_PHASE  = 3;

	typedef logic signed [SW-1:0]     sample_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct {
		cfg_idx_t           idx;
		logic [COEF_W-1:0]  data;
	} coef_write_t;

	localparam longint SMP_MAX   = (longint'(1) << (SW - 1)) - 1;
	localparam longint SMP_MIN   = -SMP_MAX - 1;
	localparam coef_t  COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t  COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
	localparam coef_t  COEF_ONE  = coef_t'(longint'(1) << CFB);
	localparam longint ROUND_HALF = longint'(1) << (CFB - 1);

	// DUT inputs, known from time zero
	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              smp_valid = 1'b0;
	sample_t           sample_in = '0;
	logic              res_stall = 1'b0;
	logic              cfg_valid = 1'b0;
	cfg_idx_t          cfg_index = CFG_B0;
	logic [COEF_W-1:0] cfg_data  = '0;

	logic    smp_stall;
	logic    res_valid;
	logic    cfg_ready;
	sample_t sample_out;

	// Filter state mirrored by the predictor
	sample_t x_hist [3] = '{default: '0};
	sample_t y_hist [3] = '{default: '0};
	coef_t   coef_reg [NUM_COEFS] = '{COEF_ONE, '0, '0, '0, '0};

	sample_t     pending_samples [$];
	sample_t     expected_out [$];
	coef_write_t pending_writes [$];

	int errors       = 0;
	int quiet_cycles = 0;
	bit calm         = 1'b0;

	biquad_iir_filter #(
		.SAMPLE_WIDTH   (SW),
		.COEF_FRAC_BITS (CFB)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.smp_valid  (smp_valid),
		.smp_stall  (smp_stall),
		.sample_in  (sample_in),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.sample_out (sample_out),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// Direct form I step: prime on zero oldest output, shift, MAC, round, clamp
	function automatic sample_t biquad_step(input sample_t x);
		longint acc;
		int     i;
		if (y_hist[2] == 0) begin
			for (i = 0; i < 3; i++) begin
				x_hist[i] = x;
				y_hist[i] = x;
			end
		end
		x_hist[2] = x_hist[1];
		x_hist[1] = x_hist[0];
		x_hist[0] = x;
		y_hist[2] = y_hist[1];
		y_hist[1] = y_hist[0];
		acc = longint'(x_hist[2]) * longint'(coef_reg[CFG_B2])
			+ longint'(x_hist[1]) * longint'(coef_reg[CFG_B1])
			+ longint'(x_hist[0]) * longint'(coef_reg[CFG_B0])
			+ longint'(y_hist[2]) * longint'(coef_reg[CFG_A2])
			+ longint'(y_hist[1]) * longint'(coef_reg[CFG_A1]);
		acc = (acc + ROUND_HALF) >>> CFB;
		if (acc > SMP_MAX)
			acc = SMP_MAX;
		if (acc < SMP_MIN)
			acc = SMP_MIN;
		y_hist[0] = sample_t'(acc);
		return y_hist[0];
	endfunction

	task automatic report(input string msg);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("%s", msg);
	endtask

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// Driver: sample and coefficient channels
	always @(posedge clk) begin
		if (arst_n) begin
			// predict on every accepted sample request
			if (smp_valid && !smp_stall)
				expected_out.push_back(biquad_step(sample_in));
			if (!smp_valid || !smp_stall) begin
				if (pending_samples.size() != 0 && !idle_now()) begin
					smp_valid <= 1'b1;
					sample_in <= pending_samples.pop_front();
				end else begin
					smp_valid <= 1'b0;
				end
			end

			// coefficient writes; out-of-range indexes are dropped
			if (cfg_valid && cfg_ready) begin
				if (cfg_index < NUM_COEFS)
					coef_reg[cfg_index] = coef_t'(cfg_data);
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_writes.size() != 0 && !idle_now()) begin
					coef_write_t w;
					w = pending_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.idx;
					cfg_data  <= w.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare results in order, random backpressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_out.size() == 0) begin
					report($sformatf("unexpected result %0d", sample_out));
				end else begin
					sample_t want;
					want = expected_out.pop_front();
					if (sample_out !== want)
						report($sformatf("sample_out mismatch: expected %0d, got %0d",
							want, sample_out));
				end
			end
			res_stall <= idle_now();
		end
	end

	// Watchdog on cycles with no request accepted anywhere
	always @(posedge clk) begin
		if (arst_n) begin
			if ((smp_valid && !smp_stall) || (res_valid && !res_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STUCK_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send_sample(input longint v);
		pending_samples.push_back(sample_t'(v));
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [COEF_W-1:0] data);
		coef_write_t w;
		w.idx  = idx;
		w.data = data;
		pending_writes.push_back(w);
	endtask

	// Wait until no request is queued, in flight or outstanding
	task automatic drain();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || smp_valid || expected_out.size() != 0
			|| pending_writes.size() != 0 || cfg_valid);
	endtask

	task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
			input coef_t a1, input coef_t a2);
		write_reg(CFG_B0, b0);
		write_reg(CFG_B1, b1);
		write_reg(CFG_B2, b2);
		write_reg(CFG_A1, a1);
		write_reg(CFG_A2, a2);
		drain();
	endtask

	function automatic coef_t rand_coef(input int mode);
		case (mode)
			0: begin
				case ($urandom_range(4))
					0:       return COEF_MIN;
					1:       return COEF_MAX;
					2:       return '0;
					3:       return COEF_ONE;
					default: return -COEF_ONE;
				endcase
			end
			1:       return coef_t'($urandom());
			// roughly +-0.25, keeps the loop mostly stable
			default: return coef_t'($urandom_range(0, 2**21) - 2**20);
		endcase
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(9))
			0:       return $urandom_range(1) ? sample_t'(SMP_MAX) : sample_t'(SMP_MIN);
			1, 2:    return '0;
			3:       return sample_t'(int'($urandom_range(0, 30)) - 15);
			default: return sample_t'($urandom());
		endcase
	endfunction

	initial begin
		int p;
		int k;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients: unity pass-through, priming on zero history
		send_sample(0);       send_sample(0);       send_sample(SMP_MAX);
		send_sample(SMP_MIN); send_sample(1);       send_sample(-1);
		send_sample(12345);   send_sample(0);
		drain();

		// max gain on b0, writes past the last register must be dropped
		load_coefs(COEF_MAX, '0, '0, '0, '0);
		write_reg(cfg_idx_t'(NUM_COEFS), '1);
		write_reg(cfg_idx_t'(NUM_COEFS + 2), COEF_MAX);
		drain();
		send_sample(SMP_MAX); send_sample(SMP_MIN); send_sample(16384); send_sample(-100);
		drain();

		// most negative coefficients everywhere
		load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
		send_sample(1000); send_sample(-1); send_sample(SMP_MAX); send_sample(SMP_MIN);
		drain();

		// most positive coefficients, runaway feedback saturates
		load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
		send_sample(500); send_sample(500); send_sample(SMP_MIN); send_sample(3);
		drain();

		// all zero: output stays zero
		load_coefs('0, '0, '0, '0, '0);
		send_sample(7); send_sample(-7);
		drain();

		// random filters and samples; drain between phases
		for (p = 0; p < RAND_PHASES; p++) begin
			calm = (p == CALM_PHASE);
			for (k = 0; k < NUM_COEFS; k++)
				write_reg(cfg_idx_t'(k), rand_coef(p % 3));
			if ($urandom_range(1))
				write_reg(cfg_idx_t'(NUM_COEFS + $urandom_range(2)), $urandom());
			drain();
			for (k = 0; k < PHASE_ITEMS; k++)
				send_sample(rand_sample());
			drain();
		end
		calm = 1'b0;

		repeat (TAIL_CYCLES) @(negedge clk);
		errors += expected_out.size();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> biquad_iir_filter.f
+incdir+rtl
rtl/biq_pkg.sv
rtl/biq_coef_regs.sv
rtl/biq_core.sv
rtl/biquad_iir_filter.sv
tb/sv/tb_top.sv
